[hdl/pzmd_pkg.sv]
// ----------------------------------------------------------------------------
// pzmd_pkg
// Shared types, constants and the control-store program for the zoned
// PID motor drive.
// ----------------------------------------------------------------------------
package pzmd_pkg;

  localparam int SAMPLE_BITS_DEF = 8;
  localparam int FULL_DUTY_DEF   = 110;

  localparam int STEP_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int PID_W      = 24;

  // duty = floor(pid * 205 / 256); any pid above DUTY_QMAX maps to 255
  localparam int DUTY_SCALE = 205;
  localparam int DUTY_QMAX  = 319;

  localparam logic signed [PID_W-1:0] PID_MAX = 24'sh7FFFFF;
  localparam logic signed [PID_W-1:0] PID_MIN = 24'sh800000;

  localparam logic [7:0] SETPOINT_RST   = 8'd127;
  localparam logic [7:0] OUTER_RST      = 8'd100;
  localparam logic [7:0] MID_RST        = 8'd90;
  localparam logic [7:0] DEAD_RST       = 8'd50;
  localparam logic [6:0] INT_LIMIT_RST  = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT  = 3'd0,
    CFG_GAIN_PROP = 3'd1,
    CFG_GAIN_INT  = 3'd2,
    CFG_GAIN_DER  = 3'd3,
    CFG_OUTER     = 3'd4,
    CFG_MID       = 3'd5,
    CFG_DEAD      = 3'd6,
    CFG_INT_LIMIT = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_LOW  = 2'd1,
    DIR_HIGH = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ZONE_HOLD  = 3'd0,
    ZONE_ABOVE = 3'd1,
    ZONE_BELOW = 3'd2,
    ZONE_UPPER = 3'd3,
    ZONE_LOWER = 3'd4,
    ZONE_DEAD  = 3'd5
  } zone_t;

  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_PROP  = 3'd1,
    MUL_INTEG = 3'd2,
    MUL_DERIV = 3'd3,
    MUL_DUTY  = 3'd4
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    JC_NEVER    = 2'd0,
    JC_NO_INPUT = 2'd1,
    JC_OUT_BUSY = 2'd2
  } jcond_t;

  typedef struct packed {
    mul_sel_t          mul;
    acc_op_t           acc;
    logic              load;
    logic              qsat;
    logic              finish;
    jcond_t            cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{mul: MUL_NONE, acc: ACC_HOLD, load: 1'b0, qsat: 1'b0,
                                 finish: 1'b0, cond: JC_NEVER, target: '0};

  // Control store: one word per step; the counter wraps from the last step to 0.
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = CTRL_NOP;
    case (step)
      3'd0: begin
        w.load   = 1'b1;
        w.cond   = JC_NO_INPUT;
        w.target = 3'd0;
      end
      3'd1: begin
        w.mul = MUL_PROP;
      end
      3'd2: begin
        w.mul = MUL_INTEG;
        w.acc = ACC_LOAD;
      end
      3'd3: begin
        w.mul = MUL_DERIV;
        w.acc = ACC_ADD;
      end
      3'd4: begin
        w.acc = ACC_ADD;
      end
      3'd5: begin
        w.qsat = 1'b1;
      end
      3'd6: begin
        w.mul = MUL_DUTY;
      end
      3'd7: begin
        w.finish = 1'b1;
        w.cond   = JC_OUT_BUSY;
        w.target = 3'd7;
      end
      default: begin
        w = CTRL_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

[hdl/pzmd_seq.sv]
// ----------------------------------------------------------------------------
// pzmd_seq
// Step counter and control store; issues one control word per cycle and
// takes the conditional jumps that wait for input and for the output slot.
// ----------------------------------------------------------------------------
module pzmd_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_busy,
  output pzmd_pkg::ctrl_t ctrl
);
  import pzmd_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              jump;

  assign ctrl = ucode_rom(step_r);

  always_comb begin
    case (ctrl.cond)
      JC_NO_INPUT: jump = !in_valid;
      JC_OUT_BUSY: jump = out_busy;
      default:     jump = 1'b0;
    endcase
  end

  // Jump to target while the condition holds, otherwise advance (wraps to 0).
  assign step_nxt = jump ? ctrl.target : step_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[hdl/pzmd_dpath.sv]
// ----------------------------------------------------------------------------
// pzmd_dpath
// Datapath: configuration registers, controller state, one shared signed
// multiplier with product register, accumulator, saturation, zone logic
// and the output register.
// ----------------------------------------------------------------------------
module pzmd_dpath #(
  parameter int SAMPLE_BITS = pzmd_pkg::SAMPLE_BITS_DEF,
  parameter int FULL_DUTY   = pzmd_pkg::FULL_DUTY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pzmd_pkg::ctrl_t                     ctrl,
  input  logic                                in_valid,
  input  logic [SAMPLE_BITS-1:0]              in_sample,
  input  logic                                out_ready,
  output logic                                out_busy,
  output logic                                out_valid,
  output logic [1:0]                          out_direction,
  output logic [7:0]                          out_duty,
  output logic signed [pzmd_pkg::PID_W-1:0]   out_pid_value,
  output logic [2:0]                          out_zone,
  input  logic                                cfg_we,
  input  logic [pzmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pzmd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pzmd_pkg::*;

  localparam int EW = SAMPLE_BITS + 1;          // error
  localparam int AW = SAMPLE_BITS + 2;          // sum and difference of errors
  localparam int ZW = SAMPLE_BITS + 2;          // zone compares
  localparam int PW = GAIN_W + AW;              // product
  localparam int SW = PW + 2;                   // sum of three products
  localparam int CW = (SW > PID_W + 1) ? SW : PID_W + 1;

  // configuration
  logic [7:0]               setpoint_r, outer_r, mid_r, dead_r;
  logic [6:0]               ilim_r;
  logic signed [GAIN_W-1:0] kp_r, ki_r, kd_r;

  // controller state
  logic signed [7:0]        error_sum_r;
  logic signed [EW-1:0]     last_error_r;
  dir_t                     held_dir_r;
  logic [7:0]               held_duty_r;

  // per-sample working registers
  logic signed [EW-1:0]     err_r;
  logic signed [7:0]        isum_r;
  logic signed [AW-1:0]     diff_r;
  zone_t                    zone_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [SW-1:0]     sum_r;
  logic signed [PID_W-1:0]  q_r;

  // output register
  logic                     out_valid_r;
  dir_t                     out_dir_r;
  logic [7:0]               out_duty_r;
  logic signed [PID_W-1:0]  out_pid_r;
  zone_t                    out_zone_r;

  logic                     load_go, finish_go;

  assign out_busy  = out_valid_r && !out_ready;
  assign load_go   = ctrl.load && in_valid;
  assign finish_go = ctrl.finish && !out_busy;

  // ---------------- sample load: error, clamped integral, difference, zone
  logic signed [EW-1:0] err_w;
  logic signed [AW-1:0] acc_w, lim_w, diff_w;
  logic signed [7:0]    isum_w;
  logic signed [ZW-1:0] s_z, sp_z, x_z, y_z, z_z;
  zone_t                zone_w;

  assign err_w  = $signed(EW'(setpoint_r)) - $signed(EW'(in_sample));
  assign acc_w  = AW'(error_sum_r) + AW'(err_w);
  assign lim_w  = $signed(AW'(ilim_r));
  assign diff_w = AW'(last_error_r) - AW'(err_w);

  always_comb begin
    if (acc_w > lim_w) begin
      isum_w = 8'(lim_w);
    end else if (acc_w < -lim_w) begin
      isum_w = 8'(-lim_w);
    end else begin
      isum_w = 8'(acc_w);
    end
  end

  assign s_z  = $signed(ZW'(in_sample));
  assign sp_z = $signed(ZW'(setpoint_r));
  assign x_z  = $signed(ZW'(outer_r));
  assign y_z  = $signed(ZW'(mid_r));
  assign z_z  = $signed(ZW'(dead_r));

  // dead band takes priority over every other zone
  always_comb begin
    if (s_z > sp_z - z_z && s_z < sp_z + z_z) begin
      zone_w = ZONE_DEAD;
    end else if (s_z >= sp_z + x_z) begin
      zone_w = ZONE_ABOVE;
    end else if (s_z < sp_z - x_z) begin
      zone_w = ZONE_BELOW;
    end else if (s_z < sp_z + x_z && s_z > sp_z + y_z) begin
      zone_w = ZONE_UPPER;
    end else if (s_z > sp_z - x_z && s_z < sp_z - y_z) begin
      zone_w = ZONE_LOWER;
    end else begin
      zone_w = ZONE_HOLD;
    end
  end

  // ---------------- shared multiplier
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [AW-1:0]     mul_b, qc_w;
  logic signed [PW-1:0]     prod_w;

  // pid above DUTY_QMAX already saturates the duty; nonpositive gives zero
  always_comb begin
    if (q_r <= 0) begin
      qc_w = '0;
    end else if (q_r > PID_W'(DUTY_QMAX)) begin
      qc_w = AW'(DUTY_QMAX);
    end else begin
      qc_w = AW'(q_r);
    end
  end

  always_comb begin
    case (ctrl.mul)
      MUL_PROP: begin
        mul_a = kp_r;
        mul_b = AW'(err_r);
      end
      MUL_INTEG: begin
        mul_a = ki_r;
        mul_b = AW'(isum_r);
      end
      MUL_DERIV: begin
        mul_a = kd_r;
        mul_b = diff_r;
      end
      MUL_DUTY: begin
        mul_a = GAIN_W'(DUTY_SCALE);
        mul_b = qc_w;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // ---------------- saturation of floor(sum / 256)
  logic signed [CW-1:0]    q_wide;
  logic signed [PID_W-1:0] q_w;

  assign q_wide = CW'(sum_r >>> 8);

  always_comb begin
    if (q_wide > CW'(PID_MAX)) begin
      q_w = PID_MAX;
    end else if (q_wide < CW'(PID_MIN)) begin
      q_w = PID_MIN;
    end else begin
      q_w = PID_W'(q_wide);
    end
  end

  // ---------------- drive selection
  dir_t       dir_w;
  logic [7:0] duty_w, pd_w;

  assign pd_w = prod_r[15:8];

  always_comb begin
    case (zone_r)
      ZONE_DEAD: begin
        dir_w  = DIR_STOP;
        duty_w = 8'd0;
      end
      ZONE_ABOVE: begin
        dir_w  = DIR_HIGH;
        duty_w = 8'(FULL_DUTY);
      end
      ZONE_BELOW: begin
        dir_w  = DIR_LOW;
        duty_w = 8'(FULL_DUTY);
      end
      ZONE_UPPER: begin
        dir_w  = DIR_HIGH;
        duty_w = pd_w;
      end
      ZONE_LOWER: begin
        dir_w  = DIR_LOW;
        duty_w = pd_w;
      end
      default: begin
        dir_w  = held_dir_r;
        duty_w = held_duty_r;
      end
    endcase
  end

  // ---------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= SETPOINT_RST;
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      outer_r      <= OUTER_RST;
      mid_r        <= MID_RST;
      dead_r       <= DEAD_RST;
      ilim_r       <= INT_LIMIT_RST;
      error_sum_r  <= '0;
      last_error_r <= '0;
      held_dir_r   <= DIR_STOP;
      held_duty_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SETPOINT:  setpoint_r <= cfg_data[7:0];
          CFG_GAIN_PROP: kp_r       <= $signed(cfg_data);
          CFG_GAIN_INT:  ki_r       <= $signed(cfg_data);
          CFG_GAIN_DER:  kd_r       <= $signed(cfg_data);
          CFG_OUTER:     outer_r    <= cfg_data[7:0];
          CFG_MID:       mid_r      <= cfg_data[7:0];
          CFG_DEAD:      dead_r     <= cfg_data[7:0];
          CFG_INT_LIMIT: ilim_r     <= cfg_data[6:0];
          default:       ;
        endcase
      end
      if (load_go) begin
        error_sum_r  <= isum_w;
        last_error_r <= err_w;
      end
      if (finish_go) begin
        held_dir_r  <= dir_w;
        held_duty_r <= duty_w;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk) begin
    if (load_go) begin
      err_r  <= err_w;
      isum_r <= isum_w;
      diff_r <= diff_w;
      zone_r <= zone_w;
    end
    if (ctrl.mul != MUL_NONE) begin
      prod_r <= prod_w;
    end
    case (ctrl.acc)
      ACC_LOAD: sum_r <= SW'(prod_r);
      ACC_ADD:  sum_r <= sum_r + SW'(prod_r);
      default:  ;
    endcase
    if (ctrl.qsat) begin
      q_r <= q_w;
    end
    if (finish_go) begin
      out_dir_r  <= dir_w;
      out_duty_r <= duty_w;
      out_pid_r  <= q_r;
      out_zone_r <= zone_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_direction = out_dir_r;
  assign out_duty      = out_duty_r;
  assign out_pid_value = out_pid_r;
  assign out_zone      = out_zone_r;

endmodule

[hdl/pid_zone_motor_drive.sv]
// ----------------------------------------------------------------------------
// pid_zone_motor_drive
// Zoned PID motor drive for a position loop, one result per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_sample carries one position sample per
//   transfer. Each sample yields exactly one result on out_valid/out_ready
//   with out_direction, out_duty, out_pid_value and out_zone.
//   Configuration is written through cfg_we/cfg_index/cfg_data only while idle,
//   a rule for the user that the block does not enforce; writes take effect at
//   the next edge; all eight indexes map to a register, so none is unknown.
//   Each sample runs through the 8-step control program: load, four products
//   through the single shared multiplier with accumulation and saturation, and
//   the output write at the last step; no new sample is taken before it ends.
//   in_ready is high only at the program's first step; the next sample is
//   taken while a finished result still waits in the output register.
//   If the receiver stalls, the program holds at its last step until the
//   output register frees, and accepts no further sample.
//   Reset loads the register defaults (setpoint 127, bands 100/90/50, limit
//   100, gains 0) and clears the integral, last error and held drive.
// ----------------------------------------------------------------------------
module pid_zone_motor_drive #(
  parameter int SAMPLE_BITS = pzmd_pkg::SAMPLE_BITS_DEF,
  parameter int FULL_DUTY   = pzmd_pkg::FULL_DUTY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [SAMPLE_BITS-1:0]              in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_direction,
  output logic [7:0]                          out_duty,
  output logic signed [pzmd_pkg::PID_W-1:0]   out_pid_value,
  output logic [2:0]                          out_zone,
  input  logic                                cfg_we,
  input  logic [pzmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pzmd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pzmd_pkg::*;

  ctrl_t ctrl;
  logic  out_busy;

  pzmd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  pzmd_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FULL_DUTY   (FULL_DUTY)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_valid      (in_valid),
    .in_sample     (in_sample),
    .out_ready     (out_ready),
    .out_busy      (out_busy),
    .out_valid     (out_valid),
    .out_direction (out_direction),
    .out_duty      (out_duty),
    .out_pid_value (out_pid_value),
    .out_zone      (out_zone),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  assign in_ready = (ctrl.cond == JC_NO_INPUT);

  // after a sample transfer the program is busy with it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after a sample transfer");

  a_dead_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zone == ZONE_DEAD |-> out_direction == DIR_STOP && out_duty == 8'd0)
    else $error("dead band result does not stop the motor");

  a_outer_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_zone == ZONE_ABOVE || out_zone == ZONE_BELOW)
      |-> out_duty == 8'(FULL_DUTY))
    else $error("outer zone result without full duty");

  a_upper_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_zone == ZONE_UPPER || out_zone == ZONE_ABOVE)
      |-> out_direction == DIR_HIGH)
    else $error("upper zone result not driving the high side");

endmodule
